/* hw/rtl/dvd_pkg.sv */
package dvd_pkg;

   localparam int FIELD_WIDTH        = 64;
   localparam int DATA_WIDTH_DEFAULT = 64;

   typedef struct packed {
      logic quo_neg;
      logic rem_neg;
      logic div_zero;
   } dvd_flags_type;

endpackage

/* hw/rtl/divider_64bit_signed_unsigned_top.sv */
// Channel   Dir  tdata (low bit up)              tuser
// req_      in   numerator[63:0], denominator     operation (1 = signed)
// rsp_      out  quotient[63:0], remainder        divide_by_zero
//
// One request enters per cycle unless rsp_tready stalls; stages: an operand
// stage, one restoring subtract stage per quotient bit, and a sign/output stage.
// Every stage has its own valid bit and takes data when it is empty or its
// successor moves, so bubbles close up under a stalled rsp_tready.
// Reset clears the valid bits only.
module divider_64bit_signed_unsigned_top import dvd_pkg::*; #(
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [2*FIELD_WIDTH-1:0] req_tdata,  // numerator, denominator
   input  logic [0:0]               req_tuser,  // operation
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [2*FIELD_WIDTH-1:0] rsp_tdata,  // quotient, remainder
   output logic [0:0]               rsp_tuser   // divide_by_zero
);

   logic                  valid_s [0:DATA_WIDTH];
   logic                  ready_s [0:DATA_WIDTH];
   logic [DATA_WIDTH-1:0] rem_s   [0:DATA_WIDTH];
   logic [DATA_WIDTH-1:0] nq_s    [0:DATA_WIDTH];
   logic [DATA_WIDTH-1:0] den_s   [0:DATA_WIDTH];
   dvd_flags_type         flags_s [0:DATA_WIDTH];

   logic [FIELD_WIDTH-1:0] quo_out, rem_out;
   logic                   dz_out;

   dvd_pre #(.DATA_WIDTH(DATA_WIDTH)) u_pre (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_num    (req_tdata[DATA_WIDTH-1:0]),
      .in_den    (req_tdata[FIELD_WIDTH +: DATA_WIDTH]),
      .in_signed (req_tuser[0]),
      .out_valid (valid_s[0]),
      .out_ready (ready_s[0]),
      .out_rem   (rem_s[0]),
      .out_nq    (nq_s[0]),
      .out_den   (den_s[0]),
      .out_flags (flags_s[0])
   );

   for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_step
      dvd_stage #(.DATA_WIDTH(DATA_WIDTH)) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (valid_s[i]),
         .in_ready  (ready_s[i]),
         .in_rem    (rem_s[i]),
         .in_nq     (nq_s[i]),
         .in_den    (den_s[i]),
         .in_flags  (flags_s[i]),
         .out_valid (valid_s[i+1]),
         .out_ready (ready_s[i+1]),
         .out_rem   (rem_s[i+1]),
         .out_nq    (nq_s[i+1]),
         .out_den   (den_s[i+1]),
         .out_flags (flags_s[i+1])
      );
   end

   dvd_post #(.DATA_WIDTH(DATA_WIDTH)) u_post (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (valid_s[DATA_WIDTH]),
      .in_ready  (ready_s[DATA_WIDTH]),
      .in_rem    (rem_s[DATA_WIDTH]),
      .in_nq     (nq_s[DATA_WIDTH]),
      .in_flags  (flags_s[DATA_WIDTH]),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_quo   (quo_out),
      .out_rem   (rem_out),
      .out_dz    (dz_out)
   );

   assign rsp_tdata = {rem_out, quo_out};
   assign rsp_tuser = dz_out;

endmodule

/* hw/rtl/dvd_pre.sv */
module dvd_pre import dvd_pkg::*; #(
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [DATA_WIDTH-1:0] in_num,
   input  logic [DATA_WIDTH-1:0] in_den,
   input  logic                  in_signed,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [DATA_WIDTH-1:0] out_rem,
   output logic [DATA_WIDTH-1:0] out_nq,
   output logic [DATA_WIDTH-1:0] out_den,
   output dvd_flags_type         out_flags
);

   logic                  valid_ff;
   logic [DATA_WIDTH-1:0] nq_ff, nq_in;
   logic [DATA_WIDTH-1:0] den_ff, den_in;
   dvd_flags_type         flags_ff, flags_in;
   logic                  dz, sgn, n_neg, d_neg;

   assign in_ready = !valid_ff || out_ready;

   // zero divisor runs the raw numerator unsigned: the steps leave it as remainder
   always_comb begin
      dz     = (in_den == '0);
      sgn    = in_signed && !dz;
      n_neg  = sgn && in_num[DATA_WIDTH-1];
      d_neg  = sgn && in_den[DATA_WIDTH-1];
      nq_in  = n_neg ? ('0 - in_num) : in_num;
      den_in = d_neg ? ('0 - in_den) : in_den;
      flags_in.quo_neg  = n_neg ^ d_neg;
      flags_in.rem_neg  = n_neg;
      flags_in.div_zero = dz;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         nq_ff    <= nq_in;
         den_ff   <= den_in;
         flags_ff <= flags_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = '0;
   assign out_nq    = nq_ff;
   assign out_den   = den_ff;
   assign out_flags = flags_ff;

endmodule

/* hw/rtl/dvd_stage.sv */
module dvd_stage import dvd_pkg::*; #(
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [DATA_WIDTH-1:0] in_rem,
   input  logic [DATA_WIDTH-1:0] in_nq,
   input  logic [DATA_WIDTH-1:0] in_den,
   input  dvd_flags_type         in_flags,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [DATA_WIDTH-1:0] out_rem,
   output logic [DATA_WIDTH-1:0] out_nq,
   output logic [DATA_WIDTH-1:0] out_den,
   output dvd_flags_type         out_flags
);

   logic                  valid_ff;
   logic [DATA_WIDTH-1:0] rem_ff, rem_in;
   logic [DATA_WIDTH-1:0] nq_ff, nq_in;
   logic [DATA_WIDTH-1:0] den_ff;
   dvd_flags_type         flags_ff;
   logic [DATA_WIDTH:0]   trial, diff;

   assign in_ready = !valid_ff || out_ready;

   // one restoring step: quotient bits shift in where numerator bits leave
   always_comb begin
      trial = {in_rem, in_nq[DATA_WIDTH-1]};
      diff  = trial - {1'b0, in_den};
      if (!diff[DATA_WIDTH]) begin
         rem_in = diff[DATA_WIDTH-1:0];
         nq_in  = {in_nq[DATA_WIDTH-2:0], 1'b1};
      end else begin
         rem_in = trial[DATA_WIDTH-1:0];
         nq_in  = {in_nq[DATA_WIDTH-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         rem_ff   <= rem_in;
         nq_ff    <= nq_in;
         den_ff   <= in_den;
         flags_ff <= in_flags;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_nq    = nq_ff;
   assign out_den   = den_ff;
   assign out_flags = flags_ff;

endmodule

/* hw/rtl/dvd_post.sv */
module dvd_post import dvd_pkg::*; #(
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [DATA_WIDTH-1:0]  in_rem,
   input  logic [DATA_WIDTH-1:0]  in_nq,
   input  dvd_flags_type          in_flags,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [FIELD_WIDTH-1:0] out_quo,
   output logic [FIELD_WIDTH-1:0] out_rem,
   output logic                   out_dz
);

   logic                  valid_ff;
   logic [DATA_WIDTH-1:0] quo_ff, quo_in;
   logic [DATA_WIDTH-1:0] rem_ff, rem_in;
   logic                  dz_ff;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      quo_in = in_flags.quo_neg ? ('0 - in_nq)  : in_nq;
      rem_in = in_flags.rem_neg ? ('0 - in_rem) : in_rem;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
         dz_ff  <= in_flags.div_zero;
      end
   end

   assign out_valid = valid_ff;
   assign out_quo   = FIELD_WIDTH'(quo_ff);
   assign out_rem   = FIELD_WIDTH'(rem_ff);
   assign out_dz    = dz_ff;

endmodule

/* hw/rtl/dvd_checker.sv */
module dvd_checker import dvd_pkg::*; #(
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_tvalid,
   input logic                     req_tready,
   input logic [2*FIELD_WIDTH-1:0] req_tdata,
   input logic [0:0]               req_tuser,
   input logic                     rsp_tvalid,
   input logic                     rsp_tready,
   input logic [2*FIELD_WIDTH-1:0] rsp_tdata,
   input logic [0:0]               rsp_tuser
);

   localparam logic [FIELD_WIDTH-1:0] MASK = FIELD_WIDTH'({DATA_WIDTH{1'b1}});

   // an empty output stage frees every stage behind it
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request refused with empty output stage");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   a_dz_result: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |->
         rsp_tdata[FIELD_WIDTH-1:0] == MASK &&
         (rsp_tdata[2*FIELD_WIDTH-1:FIELD_WIDTH] & ~MASK) == '0)
      else $error("bad zero-divisor result");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

endmodule

bind divider_64bit_signed_unsigned_top dvd_checker #(.DATA_WIDTH(DATA_WIDTH)) u_dvd_checker (.*);

/* test/tb_divider_64bit_signed_unsigned_top.sv */
`timescale 1ns / 100ps

module tb_divider_64bit_signed_unsigned_top;
   import dvd_pkg::*;

   localparam int DIV_WIDTH   = DATA_WIDTH_DEFAULT;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_REQS = 2000;

   localparam logic [FIELD_WIDTH-1:0] WIDTH_MASK = {FIELD_WIDTH{1'b1}} >> (FIELD_WIDTH - DIV_WIDTH);
   localparam logic [FIELD_WIDTH-1:0] SIGN_BIT   =
      {{(FIELD_WIDTH-1){1'b0}}, 1'b1} << (DIV_WIDTH - 1);

   typedef enum logic {
      OP_UNSIGNED = 1'b0,
      OP_SIGNED   = 1'b1
   } div_op_type;

   typedef struct {
      logic [FIELD_WIDTH-1:0] quotient;
      logic [FIELD_WIDTH-1:0] remainder;
      logic                   div_zero;
   } division_result_type;

   class divide_scoreboard;
      division_result_type pending_results[$];
      int                  fail_count;

      function automatic logic [FIELD_WIDTH-1:0] negate(input logic [FIELD_WIDTH-1:0] x);
         return (-x) & WIDTH_MASK;
      endfunction

      function void note_division(input logic [FIELD_WIDTH-1:0] num,
                                  input logic [FIELD_WIDTH-1:0] den,
                                  input div_op_type op);
         division_result_type    res;
         logic [FIELD_WIDTH-1:0] n;
         logic [FIELD_WIDTH-1:0] d;
         logic [FIELD_WIDTH-1:0] mag_n;
         logic [FIELD_WIDTH-1:0] mag_d;
         logic                   n_neg;
         logic                   d_neg;
         n = num & WIDTH_MASK;
         d = den & WIDTH_MASK;
         res.div_zero = 1'b0;
         if (d == '0) begin
            res.quotient  = WIDTH_MASK;
            res.remainder = n;
            res.div_zero  = 1'b1;
         end else if (op == OP_UNSIGNED) begin
            res.quotient  = n / d;
            res.remainder = n % d;
         end else begin
            n_neg = (n & SIGN_BIT) != '0;
            d_neg = (d & SIGN_BIT) != '0;
            mag_n = n_neg ? negate(n) : n;
            mag_d = d_neg ? negate(d) : d;
            res.quotient  = mag_n / mag_d;
            res.remainder = mag_n % mag_d;
            if (n_neg != d_neg) begin
               res.quotient = negate(res.quotient);
            end
            if (n_neg) begin
               res.remainder = negate(res.remainder);
            end
         end
         res.quotient  &= WIDTH_MASK;
         res.remainder &= WIDTH_MASK;
         pending_results.push_back(res);
      endfunction

      function void check_result(input logic [FIELD_WIDTH-1:0] quo,
                                 input logic [FIELD_WIDTH-1:0] rem,
                                 input logic dz);
         division_result_type exp_res;
         if (pending_results.size() == 0) begin
            $error("unexpected response: quotient %h remainder %h divide_by_zero %b",
                   quo, rem, dz);
            fail_count++;
            return;
         end
         exp_res = pending_results.pop_front();
         if (quo !== exp_res.quotient) begin
            $error("quotient: expected %h, actual %h", exp_res.quotient, quo);
            fail_count++;
         end
         if (rem !== exp_res.remainder) begin
            $error("remainder: expected %h, actual %h", exp_res.remainder, rem);
            fail_count++;
         end
         if (dz !== exp_res.div_zero) begin
            $error("divide_by_zero: expected %b, actual %b", exp_res.div_zero, dz);
            fail_count++;
         end
      endfunction

      function int outstanding();
         return pending_results.size();
      endfunction
   endclass

   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [2*FIELD_WIDTH-1:0] req_tdata  = '0;
   logic [0:0]               req_tuser  = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [2*FIELD_WIDTH-1:0] rsp_tdata;
   logic [0:0]               rsp_tuser;

   divide_scoreboard div_sb = new;
   bit               sender_quiet   = 1'b0;
   bit               receiver_quiet = 1'b0;
   int               cycle_count    = 0;

   divider_64bit_signed_unsigned_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic int draw_gap(input bit quiet);
      return quiet ? 0 : $urandom_range(0, 7);
   endfunction

   function automatic logic [FIELD_WIDTH-1:0] rand_operand();
      logic [FIELD_WIDTH-1:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 5))
         0: v = FIELD_WIDTH'($urandom_range(0, 15));
         1: v = -FIELD_WIDTH'($urandom_range(1, 15));
         2: v = v >> $urandom_range(1, 63);
         3: begin
            case ($urandom_range(0, 6))
               0: v = '0;
               1: v = 64'd1;
               2: v = WIDTH_MASK;
               3: v = SIGN_BIT;
               4: v = SIGN_BIT - 64'd1;
               5: v = SIGN_BIT + 64'd1;
               default: v = 64'd2;
            endcase
         end
         default: ;
      endcase
      return v;
   endfunction

   task automatic send_division(input logic [FIELD_WIDTH-1:0] num,
                                input logic [FIELD_WIDTH-1:0] den,
                                input div_op_type op);
      int gap;
      gap = draw_gap(sender_quiet);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {den, num};
      req_tuser  <= op;
      do @(posedge clock); while (!req_tready);
      div_sb.note_division(num, den, op);
   endtask

   task automatic drain_requests();
      req_tvalid <= 1'b0;
      while (div_sb.outstanding() != 0) @(posedge clock);
   endtask

   task automatic collect_results();
      int gap;
      int got;
      got = 0;
      forever begin
         gap = draw_gap(receiver_quiet);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         div_sb.check_result(rsp_tdata[FIELD_WIDTH-1:0], rsp_tdata[2*FIELD_WIDTH-1:FIELD_WIDTH],
                             rsp_tuser[0]);
         got++;
         if (got % 97 == 0) begin
            receiver_quiet = ($urandom_range(0, 3) == 0);
         end
      end
   endtask

   initial begin
      logic [FIELD_WIDTH-1:0] num;
      logic [FIELD_WIDTH-1:0] den;
      div_op_type             op;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      fork
         collect_results();
      join_none

      // corner requests
      send_division('0, '0, OP_UNSIGNED);
      send_division('0, '0, OP_SIGNED);
      send_division(WIDTH_MASK, '0, OP_UNSIGNED);
      send_division(SIGN_BIT, '0, OP_SIGNED);
      send_division(64'd5, '0, OP_SIGNED);
      send_division(WIDTH_MASK, 64'd1, OP_UNSIGNED);
      send_division(WIDTH_MASK, WIDTH_MASK, OP_UNSIGNED);
      send_division(WIDTH_MASK, 64'd2, OP_UNSIGNED);
      send_division(64'd1, WIDTH_MASK, OP_UNSIGNED);
      send_division(SIGN_BIT, WIDTH_MASK, OP_SIGNED);
      send_division(SIGN_BIT, 64'd1, OP_SIGNED);
      send_division(SIGN_BIT, SIGN_BIT, OP_SIGNED);
      send_division(SIGN_BIT - 64'd1, WIDTH_MASK, OP_SIGNED);
      send_division(SIGN_BIT - 64'd1, SIGN_BIT, OP_SIGNED);
      send_division(WIDTH_MASK, WIDTH_MASK, OP_SIGNED);
      send_division(64'd7, -64'd2, OP_SIGNED);
      send_division(-64'd7, 64'd2, OP_SIGNED);
      send_division(-64'd7, -64'd2, OP_SIGNED);
      send_division(64'd7, 64'd2, OP_SIGNED);
      send_division(-64'd7, 64'd2, OP_UNSIGNED);
      send_division(64'd123, 64'd456, OP_UNSIGNED);
      send_division(64'h0123_4567_89ab_cdef, 64'h0000_0000_fedc_ba98, OP_UNSIGNED);
      drain_requests();

      for (int i = 0; i < RANDOM_REQS; i++) begin
         if (i % 100 == 0) begin
            sender_quiet = ($urandom_range(0, 3) == 0);
         end
         if (i == RANDOM_REQS / 2) begin
            drain_requests();
         end
         num = rand_operand();
         den = ($urandom_range(0, 19) == 0) ? '0 : rand_operand();
         op  = div_op_type'($urandom_range(0, 1));
         send_division(num, den, op);
      end
      req_tvalid <= 1'b0;

      while (div_sb.outstanding() != 0) @(posedge clock);
      repeat (DIV_WIDTH + 16) @(posedge clock);
      if (div_sb.fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
